[design/binary_trie_longest_prefix_match_defines.svh]
// Assertion helpers for the checker file.
// Both expect clk and rst (synchronous, active high) in the calling scope.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH

// Same-cycle implication.
`define BTLPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTLPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/btlpm_pkg.sv]
package btlpm_pkg;

  // Default sizes of the table
  localparam int NODE_COUNT_DEF = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int ITEM_BITS_DEF  = 16;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int PLEN_W   = 6;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PLEN_W-1:0]   plen_t;

  // Operation codes
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;

  // Result codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_NO_SPACE  = 2'd2;

endpackage

[design/btlpm_req_if.sv]
interface btlpm_req_if #(
  parameter int KEY_BITS  = 32,
  parameter int ITEM_BITS = 16
);
  import btlpm_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [KEY_BITS-1:0]  key;
  plen_t                prefix_len;
  logic [ITEM_BITS-1:0] item_in;

  modport source (output valid, kind, key, prefix_len, item_in, input ready);
  modport sink   (input valid, kind, key, prefix_len, item_in, output ready);
endinterface

[design/btlpm_rsp_if.sv]
interface btlpm_rsp_if #(
  parameter int ITEM_BITS = 16
);
  import btlpm_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [ITEM_BITS-1:0] item_out;

  modport source (output valid, status, item_out, input ready);
  modport sink   (input valid, status, item_out, output ready);
endinterface

[design/binary_trie_longest_prefix_match.sv]
// Binary-trie longest-prefix-match table.
// req channel carries one request: kind (insert, lookup, delete), key,
// prefix_len and item_in. rsp channel returns one result per request:
// status (ok, not found, pool exhausted) and item_out (the matched item on
// a successful lookup, otherwise 0).
// A request walks the trie one level per cycle: the node pool memory is read
// at the next node while the current node is evaluated. Insert and delete
// walk down at most to level prefix_len, lookup at most to level KEY_BITS.
// One request is in work at a time; req.ready is high only while the block
// is idle, which it enters again as the previous result is loaded into the
// output register.
// The root node lives in flip-flops; the pool memory needs no clearing pass
// because only nodes below the allocation count are ever read, and each is
// written by the insert that links it. Reset empties the table at once.
// The result sits in an output register; if rsp.ready is low the next
// request is still taken and walked, and waits at its end until the output
// register frees up.
module binary_trie_longest_prefix_match #(
  parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS   = btlpm_pkg::KEY_BITS_DEF,
  parameter int ITEM_BITS  = btlpm_pkg::ITEM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  btlpm_req_if.sink   req,
  btlpm_rsp_if.source rsp
);
  import btlpm_pkg::*;

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(KEY_BITS + 1);
  localparam int NODE_W = 2 * IDX_W + 1 + ITEM_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state;
  kind_t                kind_r;
  logic [KEY_BITS-1:0]  key_sh;
  logic [LVL_W-1:0]     plen_r;
  logic [ITEM_BITS-1:0] item_r;
  logic [LVL_W-1:0]     lvl;
  logic [IDX_W-1:0]     node;
  logic [NODE_W-1:0]    cur;
  logic                 use_rd;
  logic [CNT_W-1:0]     nodes_used;
  logic [NODE_W-1:0]    root;
  logic                 found;
  logic [ITEM_BITS-1:0] best;
  status_t              res_status;
  logic [ITEM_BITS-1:0] res_item;
  logic                 out_valid;
  status_t              out_status;
  logic [ITEM_BITS-1:0] out_item;

  logic [NODE_W-1:0]    rd_data;
  logic [NODE_W-1:0]    e;
  logic [IDX_W-1:0]     e_child0;
  logic [IDX_W-1:0]     e_child1;
  logic                 e_valid;
  logic [ITEM_BITS-1:0] e_item;
  logic                 bit_b;
  logic [IDX_W-1:0]     child_b;
  logic [IDX_W-1:0]     new_idx;
  logic                 pool_full;

  logic                 wr;
  logic [NODE_W-1:0]    wr_data;
  logic                 step;
  logic                 alloc;
  logic                 finish;
  status_t              fin_status;
  logic [ITEM_BITS-1:0] fin_item;
  logic                 mem_we;

  // Current node content: root/fresh copy or the pool read
  assign e        = use_rd ? rd_data : cur;
  assign e_child1 = e[NODE_W-1 -: IDX_W];
  assign e_child0 = e[NODE_W-1-IDX_W -: IDX_W];
  assign e_valid  = e[ITEM_BITS];
  assign e_item   = e[ITEM_BITS-1:0];
  assign bit_b    = key_sh[KEY_BITS-1];
  assign child_b  = bit_b ? e_child1 : e_child0;
  assign new_idx  = nodes_used[IDX_W-1:0];
  assign pool_full = (nodes_used == CNT_W'(NODE_COUNT));

  // One trie level per cycle
  always_comb begin
    wr         = 1'b0;
    wr_data    = e;
    step       = 1'b0;
    alloc      = 1'b0;
    finish     = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_item   = '0;
    if (state == S_WALK) begin
      case (kind_r)
        KIND_INSERT: begin
          if (lvl == plen_r) begin
            wr         = 1'b1;
            wr_data    = {e_child1, e_child0, 1'b1, item_r};
            finish     = 1'b1;
            fin_status = ST_OK;
          end else if (child_b != '0) begin
            step = 1'b1;
          end else if (pool_full) begin
            // fresh node may still be unwritten: store it as it is
            wr         = 1'b1;
            finish     = 1'b1;
            fin_status = ST_NO_SPACE;
          end else begin
            wr      = 1'b1;
            wr_data = bit_b ? {new_idx, e_child0, e_valid, e_item}
                            : {e_child1, new_idx, e_valid, e_item};
            alloc   = 1'b1;
          end
        end
        KIND_LOOKUP: begin
          if (lvl == LVL_W'(KEY_BITS) || child_b == '0) begin
            finish = 1'b1;
            if (e_valid) begin
              fin_status = ST_OK;
              fin_item   = e_item;
            end else if (found) begin
              fin_status = ST_OK;
              fin_item   = best;
            end
          end else begin
            step = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (lvl == plen_r) begin
            wr         = 1'b1;
            wr_data    = {e_child1, e_child0, 1'b0, {ITEM_BITS{1'b0}}};
            finish     = 1'b1;
            fin_status = ST_OK;
          end else if (child_b == '0) begin
            finish = 1'b1;
          end else begin
            step = 1'b1;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  assign mem_we = wr && (node != '0);

  btlpm_node_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (NODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (node),
    .wdata (wr_data),
    .re    (step),
    .raddr (child_b),
    .rdata (rd_data)
  );

  // Sequencer and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= CNT_W'(1);
      root       <= '0;
      use_rd     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state  <= S_WALK;
            kind_r <= req.kind;
            key_sh <= req.key;
            item_r <= req.item_in;
            if (32'(req.prefix_len) > KEY_BITS) begin
              plen_r <= LVL_W'(KEY_BITS);
            end else begin
              plen_r <= LVL_W'(req.prefix_len);
            end
            lvl    <= '0;
            node   <= '0;
            cur    <= root;
            use_rd <= 1'b0;
            found  <= 1'b0;
          end
        end
        S_WALK: begin
          if (wr && node == '0) begin
            root <= wr_data;
          end
          if (e_valid) begin
            found <= 1'b1;
            best  <= e_item;
          end
          if (step) begin
            node   <= child_b;
            use_rd <= 1'b1;
            lvl    <= lvl + LVL_W'(1);
            key_sh <= key_sh << 1;
          end
          if (alloc) begin
            node       <= new_idx;
            cur        <= '0;
            use_rd     <= 1'b0;
            nodes_used <= nodes_used + CNT_W'(1);
            lvl        <= lvl + LVL_W'(1);
            key_sh     <= key_sh << 1;
          end
          if (finish) begin
            res_status <= fin_status;
            res_item   <= fin_item;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_item   <= res_item;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.item_out = out_item;

endmodule

[design/btlpm_node_ram.sv]
module btlpm_node_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/btlpm_checker.sv]
`include "binary_trie_longest_prefix_match_defines.svh"

module btlpm_checker #(
  parameter int ITEM_BITS = btlpm_pkg::ITEM_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input btlpm_pkg::status_t       rsp_status,
  input logic [ITEM_BITS-1:0]     rsp_item_out
);
  import btlpm_pkg::*;

  // Only the three defined result codes leave the block
  `BTLPM_ASSERT_IMPL(a_status_code, rsp_valid, (rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_NO_SPACE), "undefined status code")

  // A failed request never carries an item
  `BTLPM_ASSERT_IMPL(a_item_zero, rsp_valid && rsp_status != ST_OK, rsp_item_out == '0, "item on failed request")

  // One request at a time: a taken request closes the input
  `BTLPM_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

  // Stalled result holds
  `BTLPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_item_out), "stalled result changed")

endmodule

bind binary_trie_longest_prefix_match btlpm_checker #(
  .ITEM_BITS (ITEM_BITS)
) u_btlpm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_item_out (rsp.item_out)
);
